FILE: design/basic_block_partitioner_macros.svh
// ----------------------------------------------------------------------------
// Basic block partitioner assertion macros
// Shared concurrent assertion wrappers for the partitioner's checker.
// ----------------------------------------------------------------------------
`ifndef BASIC_BLOCK_PARTITIONER_MACROS_SVH
`define BASIC_BLOCK_PARTITIONER_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define BBP_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("basic_block_partitioner assertion failed");

// Expression must never be true at a rising edge outside reset.
`define BBP_ASSERT_NEVER(label, clk, rst_n, expr) \
	`BBP_ASSERT(label, clk, rst_n, !(expr))

`endif

FILE: design/bbp_pkg.sv
// ----------------------------------------------------------------------------
// Basic block partitioner package
// Fixed field widths, quad kind codes and the leader map control request.
// ----------------------------------------------------------------------------
package bbp_pkg;

	localparam int KIND_W   = 2;
	localparam int ID_W     = 6;
	localparam int POS_W    = 7;   // width of a jump target and of id + 1
	localparam int BLKNUM_W = 6;
	localparam int FIRST_W  = 6;
	localparam int LEN_W    = 7;

	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 24;

	typedef enum logic [KIND_W-1:0] {
		KIND_PLAIN     = 2'd0,
		KIND_JUMP      = 2'd1,
		KIND_LONG_JUMP = 2'd2,
		KIND_HALT      = 2'd3
	} quad_kind_t;

	// Request from the sequencer to the leader map: up to two marks a cycle,
	// or a return to the state where only position zero is a leader.
	typedef struct packed {
		logic             mark_a_en;
		logic [POS_W-1:0] mark_a_pos;
		logic             mark_b_en;
		logic [POS_W-1:0] mark_b_pos;
		logic             clear;
	} map_ctrl_t;

endpackage

FILE: design/bbp_leader_map.sv
// ----------------------------------------------------------------------------
// Leader bitmap
// One flag per program position, cleared at once to "position zero only".
// ----------------------------------------------------------------------------
module bbp_leader_map #(
	parameter int MAX_QUADS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bbp_pkg::map_ctrl_t             ctrl,
	input  logic [$clog2(MAX_QUADS+1)-1:0] rd_pos,
	output logic                           rd_leader
);

	localparam int IDX_W = $clog2(MAX_QUADS);
	localparam int CNT_W = $clog2(MAX_QUADS + 1);

	logic [MAX_QUADS-1:0] map_q;
	logic                 a_ok;
	logic                 b_ok;

	// Marks at or beyond the program limit are dropped.
	assign a_ok = ctrl.mark_a_en && (ctrl.mark_a_pos < bbp_pkg::POS_W'(MAX_QUADS));
	assign b_ok = ctrl.mark_b_en && (ctrl.mark_b_pos < bbp_pkg::POS_W'(MAX_QUADS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= MAX_QUADS'(1);
		end else if (ctrl.clear) begin
			map_q <= MAX_QUADS'(1);
		end else begin
			if (a_ok) begin
				map_q[ctrl.mark_a_pos[IDX_W-1:0]] <= 1'b1;
			end
			if (b_ok) begin
				map_q[ctrl.mark_b_pos[IDX_W-1:0]] <= 1'b1;
			end
		end
	end

	assign rd_leader = (rd_pos < CNT_W'(MAX_QUADS)) ? map_q[rd_pos[IDX_W-1:0]] : 1'b0;

endmodule

FILE: design/bbp_seq.sv
// ----------------------------------------------------------------------------
// Partition sequencer
// Loads quads, then steps one position a cycle through the leader map,
// pausing at each block boundary until the block request is taken.
module bbp_seq #(
	parameter int MAX_QUADS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// quad request
	input  logic                           in_valid,
	output logic                           in_ready,
	input  bbp_pkg::quad_kind_t            quad_kind,
	input  logic [bbp_pkg::ID_W-1:0]       quad_id,
	input  logic [bbp_pkg::POS_W-1:0]      jump_target,
	input  logic                           last_quad,
	// leader map
	output bbp_pkg::map_ctrl_t             map_ctrl,
	output logic [$clog2(MAX_QUADS+1)-1:0] rd_pos,
	input  logic                           rd_leader,
	// block request
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bbp_pkg::BLKNUM_W-1:0]   block_number,
	output logic [bbp_pkg::FIRST_W-1:0]    first_position,
	output logic [bbp_pkg::LEN_W-1:0]      block_length,
	output logic                           last_block
);

	localparam int IDX_W = $clog2(MAX_QUADS);
	localparam int CNT_W = $clog2(MAX_QUADS + 1);

	typedef enum logic [2:0] {
		S_LOAD = 3'b001,
		S_SCAN = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t                       state_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             pos_q;
	logic [IDX_W-1:0]             start_q;
	logic [bbp_pkg::BLKNUM_W-1:0] blk_q;
	logic                         out_valid_q;
	logic [bbp_pkg::BLKNUM_W-1:0] block_number_q;
	logic [bbp_pkg::FIRST_W-1:0]  first_position_q;
	logic [bbp_pkg::LEN_W-1:0]    block_length_q;
	logic                         last_block_q;

	logic accept;
	logic room;
	logic at_end;
	logic boundary;
	logic emitted;

	assign in_ready = (state_q == S_LOAD);
	assign accept   = in_valid && in_ready;
	assign room     = (count_q != CNT_W'(MAX_QUADS));
	assign at_end   = (pos_q == count_q);
	assign boundary = at_end || rd_leader;
	assign emitted  = out_valid_q && out_ready;
	assign rd_pos   = pos_q;

	// A quad beyond the limit is dropped and marks nothing.
	always_comb begin
		map_ctrl            = '0;
		map_ctrl.mark_a_pos = jump_target;
		map_ctrl.mark_b_pos = bbp_pkg::POS_W'(quad_id) + bbp_pkg::POS_W'(1);
		if (accept && room) begin
			unique case (quad_kind)
				bbp_pkg::KIND_JUMP: begin
					map_ctrl.mark_a_en = 1'b1;
				end
				bbp_pkg::KIND_LONG_JUMP: begin
					map_ctrl.mark_a_en = 1'b1;
					map_ctrl.mark_b_en = 1'b1;
				end
				bbp_pkg::KIND_HALT: begin
					map_ctrl.mark_b_pos = bbp_pkg::POS_W'(quad_id);
					map_ctrl.mark_b_en  = 1'b1;
				end
				default: begin
				end
			endcase
		end
		map_ctrl.clear = (state_q == S_EMIT) && emitted && last_block_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			pos_q       <= '0;
			start_q     <= '0;
			blk_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (room) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (last_quad) begin
							pos_q   <= CNT_W'(1);
							start_q <= '0;
							blk_q   <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (boundary) begin
						out_valid_q <= 1'b1;
						state_q     <= S_EMIT;
					end else begin
						pos_q <= pos_q + CNT_W'(1);
					end
				end
				S_EMIT: begin
					if (emitted) begin
						out_valid_q <= 1'b0;
						if (last_block_q) begin
							count_q <= '0;
							state_q <= S_LOAD;
						end else begin
							start_q <= pos_q[IDX_W-1:0];
							blk_q   <= blk_q + bbp_pkg::BLKNUM_W'(1);
							pos_q   <= pos_q + CNT_W'(1);
							state_q <= S_SCAN;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Result payload, loaded when the scan stops on a block boundary.
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && boundary) begin
			block_number_q   <= blk_q;
			first_position_q <= bbp_pkg::FIRST_W'(start_q);
			block_length_q   <= bbp_pkg::LEN_W'(pos_q - CNT_W'(start_q));
			last_block_q     <= at_end;
		end
	end

	assign out_valid      = out_valid_q;
	assign block_number   = block_number_q;
	assign first_position = first_position_q;
	assign block_length   = block_length_q;
	assign last_block     = last_block_q;

endmodule

FILE: design/basic_block_partitioner.sv
// A quad without tlast is taken and gives no result. A quad with tlast
// starts a scan of n positions (n = quads held, at most MAX_QUADS); the
// leader map is read one position per cycle, pausing at each block
// boundary until its request is taken. No new quad is taken until the
// last block of the program has been taken.
// Reset (arst_n low) empties the program and leaves only position 0 a leader.
// ----------------------------------------------------------------------------
// Basic block partitioner
// Collects jump and halt leaders of a quad program in a bitmap and, after
// the last quad, emits one request per basic block in position order.
// ----------------------------------------------------------------------------
module basic_block_partitioner #(
	parameter int MAX_QUADS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Quad stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // quad_kind[1:0], quad_id[7:2], jump_target[14:8], 0[15]
	input  logic        s_tlast,   // last_quad
	// Basic block stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // block_number[5:0], first_position[11:6],
	                               // block_length[18:12], 0[23:19]
	output logic        m_tlast    // last_block
);

	localparam int CNT_W = $clog2(MAX_QUADS + 1);

	// Fields of an incoming quad request, unpacked from tdata.
	bbp_pkg::quad_kind_t           quad_kind;
	logic [bbp_pkg::ID_W-1:0]      quad_id;
	logic [bbp_pkg::POS_W-1:0]     jump_target;

	// Fields of an outgoing block request.
	logic [bbp_pkg::BLKNUM_W-1:0]  block_number;
	logic [bbp_pkg::FIRST_W-1:0]   first_position;
	logic [bbp_pkg::LEN_W-1:0]     block_length;

	// Link between the sequencer and the leader bitmap.
	bbp_pkg::map_ctrl_t            map_ctrl;
	logic [CNT_W-1:0]              rd_pos;
	logic                          rd_leader;

	assign quad_kind   = bbp_pkg::quad_kind_t'(s_tdata[1:0]);
	assign quad_id     = s_tdata[7:2];
	assign jump_target = s_tdata[14:8];

	// The sequencer owns the quad count and the scan position. While loading
	// it marks leaders through the map's two write ports; while scanning it
	// reads one map flag per cycle and stops on each block boundary, holding
	// the result in its output register until the downstream side takes it.
	bbp_seq #(
		.MAX_QUADS(MAX_QUADS)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.quad_kind      (quad_kind),
		.quad_id        (quad_id),
		.jump_target    (jump_target),
		.last_quad      (s_tlast),
		.map_ctrl       (map_ctrl),
		.rd_pos         (rd_pos),
		.rd_leader      (rd_leader),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.block_number   (block_number),
		.first_position (first_position),
		.block_length   (block_length),
		.last_block     (m_tlast)
	);

	// One flag per position; leaders at or past MAX_QUADS are never recorded and
	// leaders past the program end are never reached by the scan.
	bbp_leader_map #(
		.MAX_QUADS(MAX_QUADS)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (map_ctrl),
		.rd_pos    (rd_pos),
		.rd_leader (rd_leader)
	);

	assign m_tdata = {5'b0, block_length, first_position, block_number};

endmodule

FILE: design/bbp_checker.sv
// ----------------------------------------------------------------------------
// Partitioner port checker
// Watches the partitioner's stream ports over time.
// ----------------------------------------------------------------------------
`include "basic_block_partitioner_macros.svh"

module bbp_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	// Quads are never taken while a block request is pending.
	`BBP_ASSERT_NEVER(a_no_load_while_emit, clk, arst_n, s_tready && m_tvalid)

	// Every block holds at least one quad.
	`BBP_ASSERT(a_len_nonzero, clk, arst_n, m_tvalid |-> (m_tdata[18:12] != 7'd0))

	// Taking the final block returns the block to loading.
	`BBP_ASSERT(a_reload, clk, arst_n, (m_tvalid && m_tready && m_tlast) |=> s_tready)

	// Taking the last quad of a program stops loading until its blocks are out.
	`BBP_ASSERT(a_scan_after_last, clk, arst_n, (s_tvalid && s_tready && s_tlast) |=> !s_tready)

	// A stalled block request holds its payload.
	`BBP_ASSERT(a_hold, clk, arst_n,
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))

endmodule

bind basic_block_partitioner bbp_port_checker u_bbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
